// ===== design/polyphase_fractional_resampler_defines.svh =====
// Assertion macros for the polyphase fractional resampler checker.
// Included by the checker file only; no other dependencies.
`ifndef POLYPHASE_FRACTIONAL_RESAMPLER_DEFINES_SVH
`define POLYPHASE_FRACTIONAL_RESAMPLER_DEFINES_SVH

// Overlapping implication, disabled while rst is high.
`define PFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define PFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pfr_pkg.sv =====
// Shared constants, register indexes, multiplier op codes and the
// datapath control struct for the polyphase fractional resampler.
// No dependencies.
`timescale 1ns / 1ps
package pfr_pkg;

  localparam int MAX_TAPS   = 256;
  localparam int MAX_PHASES = 32;
  localparam int SAMPLE_W   = 16;
  localparam int HIST_DEPTH = 256;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int COEF_AW    = $clog2(MAX_TAPS);
  localparam int ACC_W      = 58;   // holds the full blend a*2^16 + (b-a)*f
  localparam int PROD_W     = 42;   // 25 x 17 signed product
  localparam int CFG_W      = 24;   // widest register

  // configuration register indexes
  localparam logic [2:0] REG_PHASE_COUNT  = 3'd0;
  localparam logic [2:0] REG_TAP_COUNT    = 3'd1;
  localparam logic [2:0] REG_RATE_Q16     = 3'd2;
  localparam logic [2:0] REG_COEF_ADDRESS = 3'd3;
  localparam logic [2:0] REG_COEF_VALUE   = 3'd4;

  // operand selection of the shared multiplier
  localparam logic [1:0] OP_MAC  = 2'd0;  // coef * sample
  localparam logic [1:0] OP_BLO  = 2'd1;  // low 24 bits of (b-a) * frac
  localparam logic [1:0] OP_BHI  = 2'd2;  // high bits of (b-a) * frac
  localparam logic [1:0] OP_TIME = 2'd3;  // rate * L

  typedef struct packed {
    logic [1:0] op;
    logic       mul_en;      // load product register
    logic       acc_clr;
    logic       acc_add;     // acc += product
    logic       acc_add_hi;  // acc += product << 24
    logic       save_a;      // keep first sum
    logic       blend_init;  // d = b - a, acc = a << 16
  } mac_ctl_t;

endpackage

// ===== design/polyphase_fractional_resampler.sv =====
// Top level of the polyphase fractional resampler: config registers,
// sequencer, sample history and coefficient RAMs. Depends on pfr_pkg,
// pfr_ram and pfr_mac.
`timescale 1ns / 1ps
// Usage
//   Input channel in_valid/in_ready/in_sample moves one Q1.15 word per
//   handshake. Output channel out_valid/out_ready/out_sample returns zero or
//   one Q1.15 word per input word. Configuration is a write port
//   (cfg_we, cfg_index, cfg_data) used while the block is idle; index 4
//   stores cfg_data[15:0] into the coefficient RAM at the coefficient address.
// Timing
//   A word that yields an output runs two polyphase sums through the
//   single multiplier, one tap per cycle, each over the taps of its phase.
//   The shared multiply-accumulate loop sets the time a word takes.
//   in_ready is low while a word is in work.
// Reset
//   rst clears the time accumulator, history fill count and coefficient
//   valid bits and resets config; unwritten history and taps read as zero.
// Stall
//   The result sits in an output register; the next input word is taken
//   while it waits. A finished word whose result cannot be placed holds
//   until out_ready frees the register.
module polyphase_fractional_resampler
  import pfr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM_A = 3'd1;
  localparam logic [2:0] S_SUM_B = 3'd2;
  localparam logic [2:0] S_BLO   = 3'd3;
  localparam logic [2:0] S_BHI   = 3'd4;
  localparam logic [2:0] S_BADD  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]  state;
  logic [5:0]  phase_count;
  logic [8:0]  tap_count;
  logic [23:0] rate_q16;
  logic [COEF_AW-1:0] coef_address;
  logic [MAX_TAPS-1:0] coef_vld;

  logic [31:0] t;
  logic [HIST_AW-1:0] wp;
  logic [HIST_AW:0]   fill;
  logic [8:0]  m;
  logic [8:0]  h;
  logic [4:0]  ph_b;
  logic        p1_vld, p1_hv, p1_cv, p2_vld;

  // effective (clamped) settings
  logic [5:0]  lc;
  logic [8:0]  nt;
  logic [23:0] rate;

  logic        accept, cond, in_sum, issue, sum_done, out_load;
  logic signed [16:0] pos1;
  logic [4:0]  ph_a;

  logic signed [SAMPLE_W-1:0] hist_rdata, coef_rdata, samp_eff, coef_eff;
  logic [29:0] step;
  logic signed [SAMPLE_W-1:0] y_sat;
  mac_ctl_t    ctl;

  always_comb begin
    if (phase_count == 6'd0) begin
      lc = 6'd1;
    end else if (phase_count > 6'(MAX_PHASES)) begin
      lc = 6'(MAX_PHASES);
    end else begin
      lc = phase_count;
    end
    if (tap_count == 9'd0) begin
      nt = 9'd1;
    end else if (tap_count > 9'(MAX_TAPS)) begin
      nt = 9'(MAX_TAPS);
    end else begin
      nt = tap_count;
    end
    rate = (rate_q16 < 24'h010000) ? 24'h010000 : rate_q16;
  end

  // output exists when floor(t) >= -1 and floor(t)+1 < L
  assign pos1   = {t[31], t[31:16]} + 17'sd1;
  assign cond   = !pos1[16] && (pos1[15:0] < {10'b0, lc});
  assign ph_a   = (pos1 == 17'sd0) ? 5'(lc - 6'd1) : t[20:16];

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_sum   = (state == S_SUM_A) || (state == S_SUM_B);
  assign issue    = in_sum && (m < nt);
  assign sum_done = in_sum && !issue && !p1_vld && !p2_vld;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count  <= 6'd1;
      tap_count    <= 9'd1;
      rate_q16     <= 24'h010000;
      coef_address <= '0;
      coef_vld     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_COUNT:  phase_count  <= cfg_data[5:0];
        REG_TAP_COUNT:    tap_count    <= cfg_data[8:0];
        REG_RATE_Q16:     rate_q16     <= cfg_data[23:0];
        REG_COEF_ADDRESS: coef_address <= cfg_data[COEF_AW-1:0];
        REG_COEF_VALUE:   coef_vld[coef_address] <= 1'b1;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      t      <= '0;
      wp     <= '0;
      fill   <= '0;
      m      <= '0;
      h      <= '0;
      ph_b   <= '0;
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
    end else begin
      p1_vld <= issue;
      p2_vld <= p1_vld;
      case (state)
        S_IDLE: begin
          if (accept) begin
            wp <= wp + 1'b1;
            if (fill != (HIST_AW+1)'(HIST_DEPTH)) begin
              fill <= fill + 1'b1;
            end
            if (cond) begin
              m     <= {4'b0, ph_a};
              h     <= {8'b0, (pos1 == 17'sd0)};
              ph_b  <= pos1[4:0];
              state <= S_SUM_A;
            end else begin
              t <= t - {10'b0, lc, 16'b0};
            end
          end
        end
        S_SUM_A: begin
          if (issue) begin
            m <= m + {3'b0, lc};
            h <= h + 9'd1;
          end else if (sum_done) begin
            m     <= {4'b0, ph_b};
            h     <= '0;
            state <= S_SUM_B;
          end
        end
        S_SUM_B: begin
          if (issue) begin
            m <= m + {3'b0, lc};
            h <= h + 9'd1;
          end else if (sum_done) begin
            state <= S_BLO;
          end
        end
        S_BLO:  state <= S_BHI;
        S_BHI:  state <= S_BADD;
        S_BADD: state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            t     <= t + {2'b0, step} - {10'b0, lc, 16'b0};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // read-side qualifiers travel with the registered RAM data
  always_ff @(posedge clk) begin
    if (issue) begin
      p1_hv <= (h < fill);
      p1_cv <= coef_vld[m[COEF_AW-1:0]];
    end
  end

  assign samp_eff = p1_hv ? hist_rdata : '0;
  assign coef_eff = p1_cv ? coef_rdata : '0;

  always_comb begin
    ctl            = '0;
    ctl.op         = OP_MAC;
    ctl.acc_clr    = (state == S_IDLE) || ((state == S_SUM_A) && sum_done);
    ctl.save_a     = (state == S_SUM_A) && sum_done;
    ctl.blend_init = (state == S_SUM_B) && sum_done;
    ctl.mul_en     = p1_vld;
    ctl.acc_add    = p2_vld;
    case (state)
      S_BLO: begin
        ctl.op     = OP_BLO;
        ctl.mul_en = 1'b1;
      end
      S_BHI: begin
        ctl.op      = OP_BHI;
        ctl.mul_en  = 1'b1;
        ctl.acc_add = 1'b1;
      end
      S_BADD: begin
        ctl.op         = OP_TIME;
        ctl.mul_en     = 1'b1;
        ctl.acc_add_hi = 1'b1;
      end
      default: ;
    endcase
  end

  pfr_ram #(.WIDTH(SAMPLE_W), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (wp + 1'b1),
    .wdata (in_sample),
    .raddr (wp - h[HIST_AW-1:0]),
    .rdata (hist_rdata)
  );

  pfr_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_coef (
    .clk   (clk),
    .we    (cfg_we && (cfg_index == REG_COEF_VALUE)),
    .waddr (coef_address),
    .wdata (cfg_data[15:0]),
    .raddr (m[COEF_AW-1:0]),
    .rdata (coef_rdata)
  );

  pfr_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .samp  (samp_eff),
    .coef  (coef_eff),
    .frac  (t[15:0]),
    .rate  (rate),
    .lc    (lc),
    .step  (step),
    .y_sat (y_sat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= y_sat;
    end
  end

endmodule

// ===== design/pfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pfr_mac.sv =====
// Shared multiply unit with accumulator: polyphase MAC, blend and time step.
// Depends on pfr_pkg.
`timescale 1ns / 1ps
module pfr_mac
  import pfr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] samp,
  input  logic signed [15:0]         coef,
  input  logic [15:0]                frac,
  input  logic [23:0]                rate,
  input  logic [5:0]                 lc,
  output logic [29:0]                step,
  output logic signed [SAMPLE_W-1:0] y_sat
);

  logic signed [24:0]       op_a;
  logic signed [16:0]       op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] mul_q;
  logic signed [ACC_W-1:0]  acc;
  logic signed [39:0]       a_sum;
  logic signed [40:0]       d;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [26:0]       r;

  always_comb begin
    case (ctl.op)
      OP_MAC: begin
        op_a = {{(25-SAMPLE_W){samp[SAMPLE_W-1]}}, samp};
        op_b = {coef[15], coef};
      end
      OP_BLO: begin
        op_a = {1'b0, d[23:0]};
        op_b = {1'b0, frac};
      end
      OP_BHI: begin
        op_a = {{8{d[40]}}, d[40:24]};
        op_b = {1'b0, frac};
      end
      default: begin
        op_a = {1'b0, rate};
        op_b = {11'b0, lc};
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      mul_q <= prod;
    end
    if (ctl.save_a) begin
      a_sum <= acc[39:0];
    end
    if (ctl.blend_init) begin
      d <= acc[40:0] - {a_sum[39], a_sum};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.blend_init) begin
      acc <= {{(ACC_W-56){a_sum[39]}}, a_sum, 16'b0};
    end else if (ctl.acc_add) begin
      acc <= acc + {{(ACC_W-PROD_W){mul_q[PROD_W-1]}}, mul_q};
    end else if (ctl.acc_add_hi) begin
      acc <= acc + {mul_q[33:0], 24'b0};
    end
  end

  assign step = mul_q[29:0];

  // round half up, then floor shift by 31
  assign rnd = acc + (ACC_W'(1) <<< 30);
  assign r   = rnd[ACC_W-1:31];

  always_comb begin
    if (r > 27'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (r < -27'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = r[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== design/pfr_checker.sv =====
// Port-level checker for the polyphase fractional resampler, bound to the
// top level. Depends on pfr_pkg and the defines header.
`timescale 1ns / 1ps
`include "polyphase_fractional_resampler_defines.svh"
module pfr_checker
  import pfr_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_sample
);

  // a waiting result word holds
  `PFR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_sample), "output word changed while stalled")

  // results are only produced by a word in work, never while idle
  `PFR_ASSERT_NOW(a_out_from_work, clk, rst, $rose(out_valid), $past(!in_ready), "output word appeared without a word in work")

  // the block only goes busy after taking an input word
  `PFR_ASSERT_NOW(a_busy_after_accept, clk, rst, $fell(in_ready), $past(in_valid), "went busy without an accepted word")

endmodule

bind polyphase_fractional_resampler pfr_checker u_pfr_checker (.*);

// ===== dv/tb_polyphase_fractional_resampler.sv =====
// Self-checking testbench for polyphase_fractional_resampler: scoreboard class
// with a bit-true predictor, task-driven valid/ready channels and config port.
// Depends on pfr_pkg and the design sources only.
`timescale 1ns / 1ps

// Tracks the block's history, taps, output time and registers, and holds the
// output words still owed by the block.
class resample_tracker;
  logic signed [pfr_pkg::SAMPLE_W-1:0] history [pfr_pkg::HIST_DEPTH];
  logic signed [pfr_pkg::SAMPLE_W-1:0] taps [pfr_pkg::MAX_TAPS];
  logic [31:0] out_time;
  logic [5:0]  phase_reg;
  logic [8:0]  tap_reg;
  logic [23:0] rate_reg;
  logic [7:0]  addr_reg;
  logic [15:0] value_reg;
  logic signed [pfr_pkg::SAMPLE_W-1:0] due_words [$];
  int words_in;
  int words_out;
  int bad;

  function new();
    foreach (history[i]) history[i] = '0;
    foreach (taps[i]) taps[i] = '0;
    out_time  = '0;
    phase_reg = 6'd1;
    tap_reg   = 9'd1;
    rate_reg  = 24'h010000;
    addr_reg  = '0;
    value_reg = '0;
    words_in  = 0;
    words_out = 0;
    bad       = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [pfr_pkg::CFG_W-1:0] data);
    case (idx)
      pfr_pkg::REG_PHASE_COUNT:  phase_reg = data[5:0];
      pfr_pkg::REG_TAP_COUNT:    tap_reg   = data[8:0];
      pfr_pkg::REG_RATE_Q16:     rate_reg  = data[23:0];
      pfr_pkg::REG_COEF_ADDRESS: addr_reg  = data[7:0];
      pfr_pkg::REG_COEF_VALUE: begin
        value_reg      = data[15:0];
        taps[addr_reg] = data[15:0];
      end
      default: ;
    endcase
  endfunction

  // one polyphase branch: taps phase, phase+L, ... against history from offset
  function longint branch_sum(int phase, int offset, int lc, int nt);
    longint acc;
    int m;
    int j;
    acc = 0;
    m = phase;
    j = 0;
    while (m < nt) begin
      if (offset + j < pfr_pkg::HIST_DEPTH)
        acc += longint'(taps[m]) * longint'(history[offset + j]);
      m += lc;
      j++;
    end
    return acc;
  endfunction

  function void take_input(logic signed [pfr_pkg::SAMPLE_W-1:0] s);
    int lc;
    int nt;
    int f;
    int ph0;
    int off0;
    longint rate;
    longint t;
    longint pos;
    longint a;
    longint b;
    longint y;
    longint r;
    lc = int'(phase_reg);
    if (lc == 0) lc = 1;
    if (lc > pfr_pkg::MAX_PHASES) lc = pfr_pkg::MAX_PHASES;
    nt = int'(tap_reg);
    if (nt == 0) nt = 1;
    if (nt > pfr_pkg::MAX_TAPS) nt = pfr_pkg::MAX_TAPS;
    rate = longint'(rate_reg);
    if (rate < 65536) rate = 65536;
    words_in++;

    for (int i = pfr_pkg::HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = s;

    t = longint'($signed(out_time));
    pos = t >>> 16;
    if (pos >= -1 && pos + 1 < lc) begin
      f = int'(out_time[15:0]);
      // pos = -1 takes the last phase of the previous sample
      if (pos < 0) begin
        ph0  = lc - 1;
        off0 = 1;
      end else begin
        ph0  = int'(pos);
        off0 = 0;
      end
      a = branch_sum(ph0, off0, lc, nt);
      b = branch_sum(int'(pos + 1), 0, lc, nt);
      y = a * (65536 - f) + b * f;
      r = (y + (longint'(1) << 30)) >>> 31;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      due_words.push_back(16'(r));
      t += rate * lc;
    end
    t -= longint'(lc) << 16;
    out_time = t[31:0];
  endfunction

  function void check_output(logic signed [pfr_pkg::SAMPLE_W-1:0] got);
    logic signed [pfr_pkg::SAMPLE_W-1:0] want;
    words_out++;
    if (due_words.size() == 0) begin
      bad++;
      $display("%0t ns: unexpected output word, expected none, got %0d", $time, got);
      return;
    end
    want = due_words.pop_front();
    if (got !== want) begin
      bad++;
      $display("%0t ns: out_sample mismatch, expected %0d, got %0d", $time, want, got);
    end
  endfunction

  function int pending();
    return due_words.size();
  endfunction
endclass

module tb_polyphase_fractional_resampler;
  import pfr_pkg::*;

  // Longest word is two 256-tap sums through one MAC.
  localparam int     SETTLE_CYCLES = 600;
  localparam longint CYCLE_LIMIT   = 6_000_000;
  // index with no register behind it, written as noise
  localparam logic [2:0] REG_UNUSED = 3'd5;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       cfg_we = 1'b0;
  logic [2:0]                 cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;

  resample_tracker tracker;
  int     in_idle_pct = 0;
  int     out_stall_pct = 0;
  int     settings_run = 0;
  longint cycle_count = 0;

  always #1 clk = ~clk;

  polyphase_fractional_resampler dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sample(out_sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycle_count,
               tracker.pending());
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random backpressure, picked at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Output words are checked at the edge that accepts them.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_output(out_sample);
  end

  task automatic set_idle(input int mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 71; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 71; end
      default: begin in_idle_pct = 16; out_stall_pct = 16; end
    endcase
  endtask

  // Entered at a falling edge; leaves cfg_we high, the caller drops it.
  task automatic reg_write(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_tap(input int addr, input logic [15:0] value);
    logic [CFG_W-1:0] d;
    d = CFG_W'($urandom);
    d[7:0] = addr[7:0];
    reg_write(REG_COEF_ADDRESS, d);
    d = CFG_W'($urandom);
    d[15:0] = value;
    reg_write(REG_COEF_VALUE, d);
  endtask

  // Upper bits above each register's width are random; the block drops them.
  task automatic program_regs(input int lc, input int nt, input logic [23:0] rate,
                              input int coef_mode);
    logic [CFG_W-1:0] d;
    int n_load;
    d = CFG_W'($urandom);
    d[5:0] = lc[5:0];
    reg_write(REG_PHASE_COUNT, d);
    d = CFG_W'($urandom);
    d[8:0] = nt[8:0];
    reg_write(REG_TAP_COUNT, d);
    reg_write(REG_RATE_Q16, rate);
    reg_write(REG_UNUSED, CFG_W'($urandom));
    n_load = (nt == 0) ? 1 : (nt > MAX_TAPS) ? MAX_TAPS : nt;
    for (int i = 0; i < n_load; i++) begin
      if (coef_mode == 0) set_tap(i, 16'($urandom));
      else set_tap(i, 16'($urandom_range(0, 8191) - 4096));
    end
    cfg_we <= 1'b0;
  endtask

  // Entered at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high.
  task automatic push_word(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_input(s);
    @(negedge clk);
  endtask

  // Sender holds off until every owed word is out.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Idle point for register writes: drained, then a worst-case word time.
  task automatic settle();
    quiesce();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic random_words(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) quiesce();
      push_word(pick_sample());
    end
  endtask

  task automatic run_phase(input int lc, input int nt, input logic [23:0] rate,
                           input int coef_mode, input int mode, input int n);
    settle();
    program_regs(lc, nt, rate, coef_mode);
    set_idle(mode);
    settings_run++;
    random_words(n);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] edge_words [16];
    edge_words = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                   16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                   16'sh0001, 16'shffff, 16'sh0000, 16'sh5555, 16'shaaaa,
                   16'sh4000};
    tracker = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values: L=1, one zero tap, rate 1.0 -> zero words.
    set_idle(0);
    push_word(16'sh7fff);
    push_word(16'sh8000);
    push_word(16'sh0000);
    push_word(16'shffff);

    // Full-scale taps and samples drive the output into both rails;
    // rate 1.5 with L=2 walks through several fractions.
    settle();
    reg_write(REG_PHASE_COUNT, 24'd2);
    reg_write(REG_TAP_COUNT, 24'd5);
    reg_write(REG_RATE_Q16, 24'h018000);
    set_tap(0, 16'h8000);
    set_tap(1, 16'h8000);
    set_tap(2, 16'h8000);
    set_tap(3, 16'h7fff);
    set_tap(4, 16'h8000);
    cfg_we <= 1'b0;
    settings_run++;
    foreach (edge_words[i]) push_word(edge_words[i]);

    // Random part; idle pattern cycles through the four modes.
    run_phase(4, 31, 24'h014000, 0, 0, 100);
    run_phase(3, 16, 24'h028000, 1, 1, 100);          // even tap count
    run_phase(32, 256, 24'($urandom_range(65536, 262144)), 0, 2, 100);
    run_phase(1, 256, 24'h010000, 1, 3, 40);          // oldest taps past history
    run_phase(0, 0, 24'h000000, 0, 0, 60);            // all three below range
    run_phase(63, 511, 24'd1000, 1, 1, 80);           // above range, rate clamps
    run_phase(5, 45, 24'($urandom_range(65536, 262144)), 0, 2, 100);
    run_phase(2, 2, 24'($urandom_range(65536, 196608)), 1, 3, 80);
    run_phase(16, $urandom_range(1, 127) * 2 + 1,
              24'($urandom_range(65536, 1048576)), 0, 0, 100);
    run_phase(7, 101, 24'hffffff, 1, 1, 250);         // slowest output rate

    settle();
    $display("Summary: %0d input words, %0d output words checked over %0d register settings",
             tracker.words_in, tracker.words_out, settings_run);
    if (tracker.bad == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
